### hdl/jdqt_pkg.sv
// Shared types and constants for the JPEG DQT segment parser.
// Used by jdqt_front, jdqt_queue, jdqt_back and jpeg_dqt_segment_parser.
package jdqt_pkg;

  localparam int unsigned NumTablesDefault = 4;
  localparam int unsigned BlockCoeffs      = 64;
  localparam int unsigned QueueDepth       = 2;

  localparam logic [7:0] MarkerPrefix = 8'hFF;
  localparam logic [7:0] MarkerSoi    = 8'hD8;
  localparam logic [7:0] MarkerDqt    = 8'hDB;

  // Natural (row-major) position of each coefficient in zigzag order.
  localparam logic [5:0] NaturalOf [BlockCoeffs] = '{
    6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  // One decoded coefficient, passed from the parser to the output side.
  typedef struct packed {
    logic [1:0]  table_id;
    logic [5:0]  zigzag_index;
    logic [15:0] coeff_value;
    logic        table_done;
    logic [2:0]  tables_used;
  } coeff_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

### hdl/jpeg_dqt_segment_parser.sv
// JPEG DQT segment parser, top level.
// Instantiates jdqt_front, jdqt_queue and jdqt_back; depends on jdqt_pkg.
//
// Input channel (in_valid_i / in_ready_o): one beat carries one file byte and
// a file_start flag that marks the first byte of a new file. Output channel
// (out_valid_o / out_ready_i): one beat per quantizer coefficient of a table
// whose id is below NUM_TABLES, with its zigzag and natural positions, a
// last-of-table flag and the count of tables used so far.
// The parser takes one byte per cycle while the queue is not full. A
// coefficient reaches the output through the coefficient queue and then the
// output register, which also does the zigzag lookup.
// Bytes that yield no coefficient leave the output side untouched.
// When the receiver stalls, coefficients collect in the two-entry queue; the
// input is held off whenever the queue is full, even in a cycle in which the
// output beat is taken, so at most two more coefficients can queue up behind a
// stalled beat. Bytes that complete no coefficient keep flowing until then.
// Reset empties the queue and output register and leaves the parser scanning
// with two bytes to drop, as at the start of a file.
module jpeg_dqt_segment_parser
  import jdqt_pkg::*;
#(
  parameter int unsigned NUM_TABLES = NumTablesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        file_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  table_id_o,
  output logic [5:0]  zigzag_index_o,
  output logic [5:0]  natural_index_o,
  output logic [15:0] coeff_value_o,
  output logic        table_done_o,
  output logic [2:0]  tables_used_o
);

  logic          take;
  logic          push;
  coeff_t        push_data;
  logic          pop;
  coeff_t        head;
  queue_status_t q_status;

  assign in_ready_o = !q_status.full;
  assign take       = in_valid_i && in_ready_o;

  jdqt_front #(
    .NUM_TABLES (NUM_TABLES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .data_byte_i  (data_byte_i),
    .file_start_i (file_start_i),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  jdqt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  jdqt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .status_i        (q_status),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .table_id_o      (table_id_o),
    .zigzag_index_o  (zigzag_index_o),
    .natural_index_o (natural_index_o),
    .coeff_value_o   (coeff_value_o),
    .table_done_o    (table_done_o),
    .tables_used_o   (tables_used_o)
  );

`ifndef ASSERT_OFF
  // The queue can only fill up while the output register is stalled.
  a_fill_needs_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(out_valid_o && !out_ready_i))
    else $error("input held off without an output stall");

  // A table is counted before any of its coefficients leaves.
  a_tables_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (NUM_TABLES <= 4) |-> {1'b0, tables_used_o} > {2'b00, table_id_o})
    else $error("tables_used does not cover table_id");

  // The last coefficient of a table sits at the last zigzag and natural spot.
  a_done_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_done_o |-> zigzag_index_o == 6'd63 && natural_index_o == 6'd63)
    else $error("table_done on a coefficient that is not the last");

  // A push while the queue is full would lose a coefficient.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("coefficient pushed into a full queue");
`endif

endmodule

### hdl/jdqt_front.sv
// DQT byte parser on jdqt_pkg: marker scan, length and table entry decoding.
// Pushes one coeff_t per completed coefficient with table id < NUM_TABLES.
module jdqt_front
  import jdqt_pkg::*;
#(
  parameter int unsigned NUM_TABLES = NumTablesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] data_byte_i,
  input  logic       file_start_i,
  output logic       push_o,
  output coeff_t     push_data_o
);

  localparam int unsigned MaxW = $clog2(NUM_TABLES + 1);

  localparam logic [2:0] PhScan = 3'd0;
  localparam logic [2:0] PhMark = 3'd1;
  localparam logic [2:0] PhLenH = 3'd2;
  localparam logic [2:0] PhLenL = 3'd3;
  localparam logic [2:0] PhHdr  = 3'd4;
  localparam logic [2:0] PhChi  = 3'd5;
  localparam logic [2:0] PhClo  = 3'd6;

  logic [2:0]      phase_q, phase_d;
  logic [1:0]      drop_q, drop_d;
  logic            skip_q, skip_d;
  logic [15:0]     seg_q, seg_d;
  logic [7:0]      len_hi_q, len_hi_d;
  logic            wide_q, wide_d;
  logic [3:0]      cur_q, cur_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [7:0]      val_hi_q, val_hi_d;
  logic [MaxW-1:0] max_q, max_d;

  logic [15:0] seg_dec;
  logic [15:0] len_full;
  logic        hdr_id_ok;
  logic        cur_id_ok;
  logic [MaxW-1:0] hdr_id_next;

  assign seg_dec     = seg_q - 16'd1;
  assign len_full    = {len_hi_q, data_byte_i};
  assign hdr_id_ok   = {1'b0, data_byte_i[3:0]} < 5'(NUM_TABLES);
  assign cur_id_ok   = {1'b0, cur_q} < 5'(NUM_TABLES);
  assign hdr_id_next = MaxW'({1'b0, data_byte_i[3:0]} + 5'd1);

  always_comb begin
    phase_d     = phase_q;
    drop_d      = drop_q;
    skip_d      = skip_q;
    seg_d       = seg_q;
    len_hi_d    = len_hi_q;
    wide_d      = wide_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    val_hi_d    = val_hi_q;
    max_d       = max_q;
    push_o      = 1'b0;
    push_data_o = '0;
    if (take_i) begin
      if (file_start_i) begin
        // The first byte of a file restarts everything and is itself dropped.
        phase_d  = PhScan;
        drop_d   = 2'd1;
        skip_d   = 1'b0;
        seg_d    = '0;
        len_hi_d = '0;
        wide_d   = 1'b0;
        cur_d    = '0;
        cnt_d    = '0;
        val_hi_d = '0;
        max_d    = '0;
      end else if (drop_q != 2'd0) begin
        drop_d = drop_q - 2'd1;
      end else begin
        unique case (phase_q)
          PhScan: begin
            if (data_byte_i == MarkerPrefix) phase_d = PhMark;
          end
          PhMark: begin
            phase_d = PhScan;
            if (data_byte_i == MarkerSoi) begin
              skip_d = 1'b1;
            end else if (data_byte_i == MarkerDqt) begin
              if (skip_q) skip_d = 1'b0;
              else        phase_d = PhLenH;
            end
          end
          PhLenH: begin
            len_hi_d = data_byte_i;
            phase_d  = PhLenL;
          end
          PhLenL: begin
            if (len_full > 16'd2) begin
              seg_d   = len_full - 16'd2;
              phase_d = PhHdr;
            end else begin
              seg_d   = '0;
              phase_d = PhScan;
            end
          end
          PhHdr: begin
            seg_d  = seg_dec;
            wide_d = data_byte_i[7:4] != 4'd0;
            cur_d  = data_byte_i[3:0];
            cnt_d  = '0;
            if (hdr_id_ok && hdr_id_next > max_q) max_d = hdr_id_next;
            if (seg_dec == 16'd0)            phase_d = PhScan;
            else if (data_byte_i[7:4] != '0) phase_d = PhChi;
            else                             phase_d = PhClo;
          end
          PhChi: begin
            seg_d    = seg_dec;
            val_hi_d = data_byte_i;
            phase_d  = (seg_dec != 16'd0) ? PhClo : PhScan;
          end
          PhClo: begin
            seg_d = seg_dec;
            if (cur_id_ok) begin
              push_o                   = 1'b1;
              push_data_o.table_id     = cur_q[1:0];
              push_data_o.zigzag_index = cnt_q;
              push_data_o.coeff_value  = wide_q ? {val_hi_q, data_byte_i}
                                                : {8'd0, data_byte_i};
              push_data_o.table_done   = cnt_q == 6'(BlockCoeffs - 1);
              push_data_o.tables_used  = 3'(max_q);
            end
            cnt_d = cnt_q + 6'd1;
            if (seg_dec == 16'd0)                  phase_d = PhScan;
            else if (cnt_q == 6'(BlockCoeffs - 1)) phase_d = PhHdr;
            else if (wide_q)                       phase_d = PhChi;
            else                                   phase_d = PhClo;
          end
          default: phase_d = PhScan;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhScan;
      drop_q   <= 2'd2;
      skip_q   <= 1'b0;
      seg_q    <= '0;
      len_hi_q <= '0;
      wide_q   <= 1'b0;
      cur_q    <= '0;
      cnt_q    <= '0;
      val_hi_q <= '0;
      max_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      drop_q   <= drop_d;
      skip_q   <= skip_d;
      seg_q    <= seg_d;
      len_hi_q <= len_hi_d;
      wide_q   <= wide_d;
      cur_q    <= cur_d;
      cnt_q    <= cnt_d;
      val_hi_q <= val_hi_d;
      max_q    <= max_d;
    end
  end

endmodule

### hdl/jdqt_queue.sv
// Short FIFO of decoded coefficients between the parser and the output stage.
// Depends on jdqt_pkg for coeff_t, queue_status_t and QueueDepth.
module jdqt_queue
  import jdqt_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  coeff_t        push_data_i,
  input  logic          pop_i,
  output coeff_t        head_o,
  output queue_status_t status_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  coeff_t            mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign status_o.valid = count_q != '0;
  assign status_o.full  = count_q == CntW'(QueueDepth);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && status_o.valid;
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop)      count_d = count_q + CntW'(1);
    else if (do_pop && !do_push) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### hdl/jdqt_back.sv
// Output stage: maps the zigzag index to its natural position and holds the
// result beat in a register until taken. Depends on jdqt_pkg.
module jdqt_back
  import jdqt_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  coeff_t        head_i,
  input  queue_status_t status_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    table_id_o,
  output logic [5:0]    zigzag_index_o,
  output logic [5:0]    natural_index_o,
  output logic [15:0]   coeff_value_o,
  output logic          table_done_o,
  output logic [2:0]    tables_used_o
);

  logic   valid_q;
  coeff_t data_q;
  logic [5:0] natural_q;

  // If the queue holds a coefficient, the register refills in the same cycle that its beat is taken.
  assign pop_o = status_i.valid && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q    <= head_i;
      natural_q <= NaturalOf[head_i.zigzag_index];
    end
  end

  assign out_valid_o     = valid_q;
  assign table_id_o      = data_q.table_id;
  assign zigzag_index_o  = data_q.zigzag_index;
  assign natural_index_o = natural_q;
  assign coeff_value_o   = data_q.coeff_value;
  assign table_done_o    = data_q.table_done;
  assign tables_used_o   = data_q.tables_used;

endmodule
